### rtl/core/wilder_rsi_stream_core_assert.svh
// assertion macros shared by the rsi core files
`ifndef WILDER_RSI_STREAM_CORE_ASSERT_SVH
`define WILDER_RSI_STREAM_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// checked outside reset, clocked on clk
`define WRSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define WRSI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRSI_ASSERT(lbl, prop, msg)
`define WRSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/wrsi_pkg.sv
package wrsi_pkg;

	// apb register file
	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;
	localparam int RIDX_W = 1;
	localparam logic [RIDX_W-1:0] REG_PERIOD = 1'b0;

	// period register
	localparam int PERIOD_W = 9;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 9'd14;

	// averages are kept in q.16
	localparam int FRAC_W = 16;

	// result encoding, rsi times 256
	localparam int RSI_W = 15;
	localparam int OUT_DW = 16;
	localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;
	localparam logic [RSI_W-1:0] RSI_HALF = 15'd12800;

endpackage

### rtl/core/wrsi_div.sv
`include "wilder_rsi_stream_core_assert.svh"

module wrsi_div #(
	parameter int DVD_W = 64,
	parameter int DVS_W = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);
	localparam logic [CW-1:0] CNT_LD = CW'(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// one restoring step: shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	// sequencing of the bit loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LD;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

	`WRSI_ASSERT(a_div_done_end, done_q |-> (!busy_q && $past(busy_q)), "done without a run")
	`WRSI_ASSERT(a_div_load, (start && !busy_q) |=> (busy_q && cnt_q == CNT_LD), "bad load")
	`WRSI_ASSERT(a_div_rem, busy_q |-> (rem_q < dvs_q), "partial remainder out of range")

endmodule

### rtl/core/wilder_rsi_stream_core.sv
// Streaming Wilder RSI. Each beat on the s_ side carries one closing price; each beat on
// the m_ side carries RSI*256 (0..25600) and a valid flag. The first sample after reset,
// or one with first_of_series set, restarts the series and returns 0 / invalid. Over the
// first period changes gains and losses are summed; at change number period the q.16
// averages are set from the sums, and later changes smooth them. A sample before warm-up,
// or with period 0, returns 0 / invalid. One sample is in flight at a time. A sample that
// smooths the averages passes a multiply and a divide for each average; when the averages
// are first set from the sums the multiply is skipped, and when the loss average is zero
// the final division is skipped. All divisions share one bit-serial divider, 64 bits wide
// with the default parameters, that yields one quotient bit per cycle and serves the gain
// average, the loss average and the final ratio in turn; a stalled output holds the core
// in its last state. A finished result waits in the output register while the next sample
// is taken. The period register sits at APB address 0 and should only be written while no
// sample is in flight.
`include "wilder_rsi_stream_core_assert.svh"

module wilder_rsi_stream_core
	import wrsi_pkg::*;
#(
	parameter int MAX_PERIOD = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ADDR_W-1:0]                     paddr,
	input  logic [APB_DW-1:0]                     pwdata,
	output logic [APB_DW-1:0]                     prdata,
	output logic                                  pready,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// close_price
	input  logic [((PRICE_BITS + 7) / 8) * 8-1:0] s_tdata,
	// first_of_series
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// rsi_value
	output logic [OUT_DW-1:0]                     m_tdata,
	// rsi_valid
	output logic                                  m_tuser
);

	localparam int PW     = $clog2(MAX_PERIOD + 1);
	localparam int CNT_W  = $clog2(MAX_PERIOD + 2);
	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_PERIOD);
	localparam int AVG_W  = PRICE_BITS + FRAC_W;
	localparam int MB_W   = (PW > RSI_W) ? PW : RSI_W;
	localparam int PROD_W = AVG_W + MB_W;
	localparam int DVD_W  = PROD_W + 1;
	localparam int DVS_W  = AVG_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PERIOD + 1);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_STEP      = 4'd1;
	localparam logic [3:0] ST_AVG_MUL   = 4'd2;
	localparam logic [3:0] ST_AVG_START = 4'd3;
	localparam logic [3:0] ST_AVG_WAIT  = 4'd4;
	localparam logic [3:0] ST_RSI       = 4'd5;
	localparam logic [3:0] ST_RSI_START = 4'd6;
	localparam logic [3:0] ST_RSI_WAIT  = 4'd7;
	localparam logic [3:0] ST_FIN       = 4'd8;

	logic [3:0]            state_q;
	logic                  sel_q;
	logic                  init_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PERIOD_W-1:0]   period_q;
	logic                  m_tvalid_q;

	logic [PRICE_BITS-1:0] price_q;
	logic                  first_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic [PRICE_BITS-1:0] gain_q;
	logic [PRICE_BITS-1:0] loss_q;
	logic [SUM_W-1:0]      gain_sum_q;
	logic [SUM_W-1:0]      loss_sum_q;
	logic [AVG_W-1:0]      avg_g_q;
	logic [AVG_W-1:0]      avg_l_q;
	logic [PROD_W-1:0]     prod_q;
	logic [RSI_W-1:0]      res_val_q;
	logic                  res_vld_q;
	logic [RSI_W-1:0]      out_val_q;
	logic                  out_vld_q;

	logic                  cfg_wr;
	logic [RIDX_W-1:0]     reg_idx;
	logic [PW-1:0]         p_w;
	logic [CNT_W-1:0]      p_ext;
	logic                  s_acc;
	logic                  restart;
	logic                  out_free;
	logic [PRICE_BITS-1:0] gain_w;
	logic [PRICE_BITS-1:0] loss_w;
	logic [AVG_W-1:0]      mul_a;
	logic [MB_W-1:0]       mul_b;
	logic [PRICE_BITS-1:0] x_sel;
	logic [SUM_W-1:0]      sum_sel;
	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic [DVD_W-1:0]      div_dvd;
	logic [DVS_W-1:0]      div_dvs;
	logic [DVD_W-1:0]      div_q;

	// register port
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_PERIOD) ? APB_DW'(period_q) : '0;

	// period clamped to the largest supported value
	assign p_w   = (32'(period_q) > 32'(MAX_PERIOD)) ? PW'(MAX_PERIOD) : PW'(period_q);
	assign p_ext = CNT_W'(p_w);

	// handshake helpers
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign restart  = first_q || (cnt_q == '0);

	// price change split into gain and loss
	assign gain_w = (price_q > prev_q) ? price_q - prev_q : '0;
	assign loss_w = (price_q < prev_q) ? prev_q - price_q : '0;

	// operand selection for the shared multiplier and divider
	assign x_sel   = sel_q ? loss_q : gain_q;
	assign sum_sel = sel_q ? loss_sum_q : gain_sum_q;
	assign mul_a   = (state_q == ST_RSI) ? avg_g_q : (sel_q ? avg_l_q : avg_g_q);
	assign mul_b   = (state_q == ST_RSI) ? MB_W'(RSI_FULL) : MB_W'(p_w - 1'b1);

	assign div_start = (state_q == ST_AVG_START) || (state_q == ST_RSI_START);

	always_comb begin
		if (state_q == ST_RSI_START) begin
			div_dvd = DVD_W'(prod_q);
			div_dvs = {1'b0, avg_g_q} + {1'b0, avg_l_q};
		end else begin
			div_dvs = DVS_W'(p_w);
			if (init_q)
				div_dvd = DVD_W'({sum_sel, {FRAC_W{1'b0}}});
			else
				div_dvd = DVD_W'(prod_q) + DVD_W'({x_sel, {FRAC_W{1'b0}}});
		end
	end

	wrsi_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q)
	);

	// sequencer, sample counter and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sel_q      <= 1'b0;
			init_q     <= 1'b0;
			cnt_q      <= '0;
			period_q   <= PERIOD_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr && reg_idx == REG_PERIOD)
				period_q <= pwdata[PERIOD_W-1:0];
			// output beat loads in the last state, clears once taken
			if (state_q == ST_FIN && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc)
						state_q <= ST_STEP;
				end
				ST_STEP: begin
					sel_q  <= 1'b0;
					init_q <= (cnt_q == p_ext);
					if (restart) begin
						cnt_q   <= CNT_W'(1);
						state_q <= ST_FIN;
					end else begin
						if (cnt_q < CNT_MAX)
							cnt_q <= cnt_q + 1'b1;
						if (p_w == '0 || cnt_q < p_ext)
							state_q <= ST_FIN;
						else if (cnt_q == p_ext)
							state_q <= ST_AVG_START;
						else
							state_q <= ST_AVG_MUL;
					end
				end
				ST_AVG_MUL:   state_q <= ST_AVG_START;
				ST_AVG_START: state_q <= ST_AVG_WAIT;
				ST_AVG_WAIT: begin
					if (div_done) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= init_q ? ST_AVG_START : ST_AVG_MUL;
						end else begin
							state_q <= ST_RSI;
						end
					end
				end
				ST_RSI:       state_q <= (avg_l_q == '0) ? ST_FIN : ST_RSI_START;
				ST_RSI_START: state_q <= ST_RSI_WAIT;
				ST_RSI_WAIT: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// series state and result datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			price_q <= s_tdata[PRICE_BITS-1:0];
			first_q <= s_tuser;
		end
		unique case (state_q)
			ST_STEP: begin
				prev_q    <= price_q;
				gain_q    <= gain_w;
				loss_q    <= loss_w;
				res_val_q <= '0;
				res_vld_q <= 1'b0;
				if (restart) begin
					gain_sum_q <= '0;
					loss_sum_q <= '0;
					avg_g_q    <= '0;
					avg_l_q    <= '0;
				end else if (p_w != '0 && cnt_q <= p_ext) begin
					gain_sum_q <= gain_sum_q + SUM_W'(gain_w);
					loss_sum_q <= loss_sum_q + SUM_W'(loss_w);
				end
			end
			ST_AVG_MUL: prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			ST_AVG_WAIT: begin
				if (div_done) begin
					if (sel_q)
						avg_l_q <= div_q[AVG_W-1:0];
					else
						avg_g_q <= div_q[AVG_W-1:0];
				end
			end
			ST_RSI: begin
				// no loss at all gives a fixed answer
				prod_q    <= PROD_W'(mul_a) * PROD_W'(mul_b);
				res_vld_q <= 1'b1;
				res_val_q <= (avg_g_q != '0) ? RSI_FULL : RSI_HALF;
			end
			ST_RSI_WAIT: begin
				if (div_done)
					res_val_q <= div_q[RSI_W-1:0];
			end
			ST_FIN: begin
				if (out_free) begin
					out_val_q <= res_val_q;
					out_vld_q <= res_vld_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'(out_val_q);
	assign m_tuser  = out_vld_q;

	`WRSI_ASSERT(a_busy_no_input, div_busy |-> !s_tready, "input taken while divider runs")
	`WRSI_ASSERT(a_start_free, div_start |-> !div_busy, "divider restarted while busy")
	`WRSI_ASSERT(a_cnt_sat, cnt_q <= CNT_MAX, "sample count past saturation")
	`WRSI_ASSERT(a_invalid_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "invalid beat not zero")
	`WRSI_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "output beat during reset")

endmodule

### dv/tb_wilder_rsi_stream_core.sv
`timescale 1ns / 100ps

module tb_wilder_rsi_stream_core;
	import wrsi_pkg::*;

	localparam int MAX_PERIOD = 256;
	localparam int PRICE_BITS = 32;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 250;
	localparam logic [ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};

	typedef struct packed {
		logic [RSI_W-1:0] value;
		logic             valid;
	} rsi_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// close_price
	logic [PRICE_BITS-1:0] s_tdata = '0;
	// first_of_series
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// rsi_value, zero padded
	logic [OUT_DW-1:0]     m_tdata;
	// rsi_valid
	logic                  m_tuser;

	// predictor state
	logic [PERIOD_W-1:0]   period_mirror = PERIOD_RST;
	logic [31:0]           prev_close = '0;
	logic [8:0]            n_seen = '0;
	logic [39:0]           sum_up = '0;
	logic [39:0]           sum_dn = '0;
	logic [47:0]           avg_up = '0;
	logic [47:0]           avg_dn = '0;

	rsi_beat_t             expected_rsi[$];

	int                    n_sent = 0;
	int                    n_checked = 0;
	int                    n_valid = 0;
	int                    n_restarts = 0;
	int                    n_periods = 0;
	int                    n_errors = 0;
	int                    burst_left = 0;
	int                    quiet_cycles = 0;
	logic [10:0]           rx_tick = '0;

	wilder_rsi_stream_core #(
		.MAX_PERIOD(MAX_PERIOD),
		.PRICE_BITS(PRICE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// next rsi beat for one closing price, updates the predictor state
	function automatic rsi_beat_t wilder_rsi_next(input logic [31:0] price,
			input logic restart);
		rsi_beat_t   res;
		logic [8:0]  p;
		logic [8:0]  idx;
		logic [31:0] up;
		logic [31:0] dn;
		logic [79:0] g;
		logic [79:0] l;
		logic [79:0] num;
		res = '0;
		p = (period_mirror > MAX_PERIOD) ? 9'(MAX_PERIOD) : period_mirror;
		// new series: clear everything and keep the price
		if (restart || n_seen == 0) begin
			sum_up = '0;
			sum_dn = '0;
			avg_up = '0;
			avg_dn = '0;
			prev_close = price;
			n_seen = 9'd1;
			return res;
		end
		idx = n_seen;
		if (n_seen < MAX_PERIOD + 1)
			n_seen = n_seen + 9'd1;
		up = (price > prev_close) ? price - prev_close : '0;
		dn = (price < prev_close) ? prev_close - price : '0;
		prev_close = price;
		if (p != 0) begin
			// warm-up sums, then wilder smoothing in q.16
			if (idx <= p) begin
				sum_up = sum_up + up;
				sum_dn = sum_dn + dn;
				if (idx == p) begin
					avg_up = 48'((64'(sum_up) << FRAC_W) / p);
					avg_dn = 48'((64'(sum_dn) << FRAC_W) / p);
				end
			end else begin
				avg_up = 48'((64'(avg_up) * (p - 9'd1) + (64'(up) << FRAC_W)) / p);
				avg_dn = 48'((64'(avg_dn) * (p - 9'd1) + (64'(dn) << FRAC_W)) / p);
			end
			if (idx >= p) begin
				res.valid = 1'b1;
				g = 80'(avg_up);
				l = 80'(avg_dn);
				if (l == 0) begin
					res.value = (g != 0) ? RSI_FULL : RSI_HALF;
				end else begin
					num = (80'(RSI_FULL) * g) / (g + l);
					res.value = RSI_W'(num);
				end
			end
		end
		return res;
	endfunction

	// random walk with jumps to the rails and flat stretches
	function automatic logic [31:0] pick_close(input logic [31:0] prev);
		logic [31:0] step;
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return '0;
			2: return '1;
			3, 4: return prev;
			default: begin
				step = $urandom_range(0, 1 << $urandom_range(0, 16));
				if ($urandom_range(0, 1) == 1)
					return (prev > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : prev + step;
				else
					return (prev < step) ? 32'h0 : prev - step;
			end
		endcase
	endfunction

	// one price beat, sent in bursts with random gaps
	task automatic push_close(input logic [31:0] price, input logic restart);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 300)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= price;
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		expected_rsi.push_back(wilder_rsi_next(price, restart));
		burst_left--;
		n_sent++;
		if (restart)
			n_restarts++;
	endtask

	// stop sending and wait for every result to come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_rsi.size() != 0);
	endtask

	// apb read of the period register, compared to the expected value
	task automatic apb_read_check(input logic [PERIOD_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PERIOD_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(want)) begin
			n_errors++;
			if (n_errors <= 10)
				$display("period readback: expected %0d, got %0d", want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// apb write of the period register, only while the core is idle
	task automatic set_period(input logic [PERIOD_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PERIOD_ADDR;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		period_mirror = value;
		n_periods++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apb_read_check(value);
	endtask

	// one series of random prices, sometimes broken by a stray restart
	task automatic run_series(input int length, input logic lead_restart);
		logic [31:0] px;
		logic        restart;
		px = $urandom;
		for (int k = 0; k < length; k++) begin
			restart = (k == 0 && lead_restart) || ($urandom_range(0, 59) == 0);
			px = pick_close(px);
			push_close(px, restart);
		end
	endtask

	task automatic test_reset_and_register();
		apb_read_check(PERIOD_RST);
		set_period(9'd2);
	endtask

	// rails, flat prices, no-loss and no-move cases, restarts, period 0 and clamp
	task automatic test_directed_cases();
		push_close(32'h0, 1'b0);
		push_close(32'hFFFF_FFFF, 1'b0);
		push_close(32'hFFFF_FFFF, 1'b0);
		push_close(32'h0, 1'b0);
		push_close(32'h0, 1'b0);
		push_close(32'd5, 1'b1);
		push_close(32'd5, 1'b0);
		push_close(32'd5, 1'b0);
		push_close(32'd3, 1'b0);
		drain_results();
		set_period(9'd0);
		push_close(32'd9, 1'b0);
		push_close(32'd1, 1'b0);
		drain_results();
		set_period(9'd1);
		push_close(32'd7, 1'b1);
		push_close(32'd8, 1'b0);
		drain_results();
		set_period(9'd300);
		push_close(32'd4, 1'b0);
		drain_results();
	endtask

	// period moved above and then below the running index
	task automatic test_period_changes();
		set_period(9'd3);
		push_close(32'd100, 1'b1);
		push_close(32'd110, 1'b0);
		push_close(32'd90, 1'b0);
		push_close(32'd120, 1'b0);
		push_close(32'd115, 1'b0);
		drain_results();
		set_period(9'd8);
		push_close(32'd130, 1'b0);
		push_close(32'd125, 1'b0);
		push_close(32'd140, 1'b0);
		push_close(32'd135, 1'b0);
		drain_results();
		set_period(9'd1);
		push_close(32'd100, 1'b0);
		push_close(32'd100, 1'b0);
		drain_results();
	endtask

	// largest period, long enough for the sample count to saturate
	task automatic test_long_period();
		set_period(9'(MAX_PERIOD));
		run_series(300, 1'b1);
		drain_results();
	endtask

	task automatic test_random_series(input int budget);
		int         start;
		logic [8:0] p;
		start = n_sent;
		while (n_sent - start < budget) begin
			case ($urandom_range(0, 9))
				0: p = 9'd0;
				1: p = 9'd1;
				2: p = 9'd2;
				3: p = 9'($urandom_range(3, 8));
				default: p = 9'($urandom_range(4, 30));
			endcase
			set_period(p);
			repeat ($urandom_range(1, 3))
				run_series(p + 1 + $urandom_range(0, 2 * p + 12), $urandom_range(0, 3) != 0);
			drain_results();
		end
	endtask

	// receiver stall pattern: open, coin flip, long hold, sparse
	always @(posedge clk) begin
		rx_tick <= rx_tick + 11'd1;
		case (rx_tick[10:9])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= (rx_tick[8:0] >= 9'd400);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// compare each result beat against the oldest prediction
	always @(posedge clk) begin : check_rsi
		rsi_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rsi.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result beat: rsi_value %0d rsi_valid %0b",
						m_tdata, m_tuser);
			end else begin
				want = expected_rsi.pop_front();
				n_checked++;
				if (want.valid)
					n_valid++;
				if (m_tdata !== OUT_DW'(want.value) || m_tuser !== want.valid) begin
					n_errors++;
					if (n_errors <= 10)
						$display("beat %0d: rsi_value exp %0d got %0d, rsi_valid exp %0b got %0b",
							n_checked, want.value, m_tdata, want.valid, m_tuser);
				end
			end
		end
	end

	// give up after a long stretch with no beat on any port
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		// reset edge lands after every process waits on it
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_register();
		test_directed_cases();
		test_period_changes();
		test_long_period();
		test_random_series(525);
		drain_results();
		// catch stray beats after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d prices over %0d period settings with %0d series restarts",
			n_sent, n_periods, n_restarts);
		$display("checked %0d rsi beats, %0d past warm-up, %0d mismatches",
			n_checked, n_valid, n_errors);
		if (n_errors == 0 && expected_rsi.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
